// File: hw/rtl/lrd_pkg.sv
// ----------------------------------------------------------------------------
// lrd_pkg: shared types, codes and the CRC step of the record deframer
// Holds the parser phases, the result beat layout and the CRC-32 byte update.
// ----------------------------------------------------------------------------
package lrd_pkg;

    localparam int unsigned MAX_KEY_BYTES   = 256;
    localparam int unsigned MAX_VALUE_BYTES = 1024;
    localparam int unsigned BODY_LIMIT      = 7 + MAX_KEY_BYTES + MAX_VALUE_BYTES;
    localparam logic [31:0] CRC_POLY        = 32'hEDB8_8320;

    // configuration register indexes
    localparam logic [1:0] CFG_HDR_BE   = 2'd0;
    localparam logic [1:0] CFG_PUT_CODE = 2'd1;

    // item kinds
    localparam logic [1:0] KIND_KEY   = 2'd0;
    localparam logic [1:0] KIND_VALUE = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;
    localparam logic [1:0] KIND_STOP  = 2'd3;

    // status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_BAD_LEN = 3'd1;
    localparam logic [2:0] ST_CRC     = 3'd2;
    localparam logic [2:0] ST_TRUNC   = 3'd3;
    localparam logic [2:0] ST_CLEAN   = 3'd4;

    typedef enum logic [2:0] {
        PH_CRC, PH_LEN, PH_TYPE, PH_KLEN, PH_KEY, PH_VLEN, PH_VALUE
    } t_phase;

    typedef struct packed {
        logic       end_marker;
        logic [7:0] log_byte;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]  item_kind;
        logic [7:0]  data_byte;
        logic [7:0]  record_kind;
        logic        record_end;
        logic [2:0]  status;
        logic [8:0]  key_length;
        logic [10:0] value_length;
    } t_result;

    typedef struct packed {
        logic       header_big_endian;
        logic [7:0] put_type_code;
    } t_cfg;

    // reflected CRC-32, one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// File: hw/rtl/log_record_deframer_crc_check.sv
// ----------------------------------------------------------------------------
// log_record_deframer_crc_check: log record deframer with CRC-32 check
// Splits a length-prefixed log byte stream into key/value beats and verdicts.
// ----------------------------------------------------------------------------
// Push one log byte (or the end marker) per beat; pop key bytes, value bytes,
// record-end verdicts and stop beats. The parser handles one byte per clock
// when not stalled, so the sustained rate is one beat per cycle, set by the
// byte-wide CRC-32 update and field counter in the parser. Input beats pass
// through a two-entry queue; results wait in a four-entry queue, so the input
// side keeps moving while a result is not yet popped. Once the parser stops
// (bad length, CRC mismatch, truncation or clean end) it swallows all later
// bytes until reset. Configuration writes belong in idle periods. The delete
// type code register is accepted on the port but needs no storage: any type
// other than the put code is handled as a record without value bytes.
// ----------------------------------------------------------------------------
module log_record_deframer_crc_check
    import lrd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_wdata,
    // input queue side
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_log_byte,
    input  logic        i_end_marker,
    // result queue side
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_item_kind,
    output logic [7:0]  o_data_byte,
    output logic [7:0]  o_record_kind,
    output logic        o_record_end,
    output logic [2:0]  o_status,
    output logic [8:0]  o_key_length,
    output logic [10:0] o_value_length
);
    t_cfg     r_cfg;
    t_in_beat in_beat, front_beat;
    logic     front_empty, out_full, take;
    logic     res_valid;
    t_result  res, out_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_big_endian <= 1'b0;
            r_cfg.put_type_code     <= 8'd0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_HDR_BE)   r_cfg.header_big_endian <= i_cfg_wdata[0];
            if (i_cfg_idx == CFG_PUT_CODE) r_cfg.put_type_code     <= i_cfg_wdata;
        end
    end

    assign in_beat.log_byte   = i_log_byte;
    assign in_beat.end_marker = i_end_marker;

    lrd_in_fifo u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (push),
        .i_wdata (in_beat),
        .o_full  (full),
        .i_rd    (take),
        .o_empty (front_empty),
        .o_rdata (front_beat)
    );

    // a beat moves into the parser only when the result queue has room
    assign take = !front_empty && !out_full;

    lrd_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (take),
        .i_beat      (front_beat),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    lrd_out_fifo u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_valid),
        .i_wdata (res),
        .o_full  (out_full),
        .i_rd    (pop),
        .o_empty (empty),
        .o_rdata (out_res)
    );

    assign o_item_kind    = out_res.item_kind;
    assign o_data_byte    = out_res.data_byte;
    assign o_record_kind  = out_res.record_kind;
    assign o_record_end   = out_res.record_end;
    assign o_status       = out_res.status;
    assign o_key_length   = out_res.key_length;
    assign o_value_length = out_res.value_length;

endmodule

// File: hw/rtl/lrd_in_fifo.sv
// ----------------------------------------------------------------------------
// lrd_in_fifo: front queue of log beats
// Two-entry queue between the input port and the parser.
// ----------------------------------------------------------------------------
module lrd_in_fifo
    import lrd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_wr,
    input  t_in_beat i_wdata,
    output logic     o_full,
    input  logic     i_rd,
    output logic     o_empty,
    output t_in_beat o_rdata
);
    t_in_beat   r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_wr && !o_full) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_wr && !o_full) r_wptr <= ~r_wptr;
            if (i_rd && !o_empty) r_rptr <= ~r_rptr;
            r_count <= r_count + 2'(i_wr && !o_full) - 2'(i_rd && !o_empty);
        end
    end

    a_in_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2) else $error("input queue overfilled");

endmodule

// File: hw/rtl/lrd_parse.sv
// ----------------------------------------------------------------------------
// lrd_parse: record parser and CRC checker
// Walks the record fields one byte per beat and produces result beats.
// ----------------------------------------------------------------------------
module lrd_parse
    import lrd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_valid,
    input  t_in_beat i_beat,
    output logic     o_res_valid,
    output t_result  o_res
);
    t_phase      r_phase, n_phase;
    logic [10:0] r_cnt, n_cnt;
    logic [31:0] r_shift, n_shift;
    logic [31:0] r_stored, n_stored;
    logic [31:0] r_crc, n_crc;
    logic [10:0] r_body, n_body;
    logic [7:0]  r_type, n_type;
    logic [8:0]  r_klen, n_klen;
    logic [10:0] r_vlen, n_vlen;
    logic        r_halted, n_halted;

    logic [7:0]  b;
    logic [31:0] crc_next, hdr_shift, vsh;
    logic [15:0] ksh;
    logic [11:0] cnt_inc;
    logic [1:0]  kind;
    logic [7:0]  dbyte;
    logic        rend, emit;
    logic [2:0]  stat;

    always_comb begin
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_shift  = r_shift;
        n_stored = r_stored;
        n_crc    = r_crc;
        n_body   = r_body;
        n_type   = r_type;
        n_klen   = r_klen;
        n_vlen   = r_vlen;
        n_halted = r_halted;
        emit     = 1'b0;
        kind     = KIND_STOP;
        dbyte    = 8'd0;
        rend     = 1'b0;
        stat     = ST_OK;

        b         = i_beat.log_byte;
        crc_next  = crc_byte(r_crc, b);
        hdr_shift = i_cfg.header_big_endian ? {r_shift[23:0], b}
                  : (r_shift | ({24'd0, b} << {r_cnt[1:0], 3'b000}));
        ksh       = {r_shift[7:0], b};
        vsh       = {r_shift[23:0], b};
        cnt_inc   = {1'b0, r_cnt} + 12'd1;

        if (i_valid && !r_halted) begin
            if (i_beat.end_marker) begin
                emit     = 1'b1;
                n_halted = 1'b1;
                stat     = (r_phase == PH_CRC && r_cnt == 11'd0) ? ST_CLEAN : ST_TRUNC;
            end else begin
                unique case (r_phase)
                    PH_CRC: begin
                        if (r_cnt == 11'd0) begin
                            n_type = 8'd0;
                            n_klen = 9'd0;
                            n_vlen = 11'd0;
                        end
                        if (r_cnt[1:0] == 2'd3) begin
                            n_stored = hdr_shift;
                            n_phase  = PH_LEN;
                            n_cnt    = 11'd0;
                            n_shift  = 32'd0;
                        end else begin
                            n_shift = hdr_shift;
                            n_cnt   = cnt_inc[10:0];
                        end
                    end
                    PH_LEN: begin
                        if (r_cnt[1:0] == 2'd3) begin
                            n_cnt   = 11'd0;
                            n_shift = 32'd0;
                            if (hdr_shift == 32'd0 || hdr_shift > 32'(BODY_LIMIT)) begin
                                emit     = 1'b1;
                                n_halted = 1'b1;
                                stat     = ST_BAD_LEN;
                            end else begin
                                n_body  = hdr_shift[10:0];
                                n_crc   = '1;
                                n_phase = PH_TYPE;
                            end
                        end else begin
                            n_shift = hdr_shift;
                            n_cnt   = cnt_inc[10:0];
                        end
                    end
                    PH_TYPE: begin
                        n_crc   = crc_next;
                        n_type  = b;
                        n_phase = PH_KLEN;
                    end
                    PH_KLEN: begin
                        n_crc = crc_next;
                        if (r_cnt == 11'd0) begin
                            n_shift = {16'd0, ksh};
                            n_cnt   = 11'd1;
                        end else begin
                            n_klen  = ksh[8:0];
                            n_cnt   = 11'd0;
                            n_shift = 32'd0;
                            if (ksh > 16'(MAX_KEY_BYTES) ||
                                (12'd7 + {3'd0, ksh[8:0]}) > {1'b0, r_body}) begin
                                emit     = 1'b1;
                                n_halted = 1'b1;
                                stat     = ST_BAD_LEN;
                            end else begin
                                n_phase = (ksh != 16'd0) ? PH_KEY : PH_VLEN;
                            end
                        end
                    end
                    PH_KEY: begin
                        n_crc = crc_next;
                        n_cnt = cnt_inc[10:0];
                        if (cnt_inc >= {3'd0, r_klen}) begin
                            n_phase = PH_VLEN;
                            n_cnt   = 11'd0;
                            n_shift = 32'd0;
                        end
                        emit  = 1'b1;
                        kind  = KIND_KEY;
                        dbyte = b;
                    end
                    PH_VLEN: begin
                        n_crc = crc_next;
                        if (r_cnt[1:0] != 2'd3) begin
                            n_shift = vsh;
                            n_cnt   = cnt_inc[10:0];
                        end else begin
                            n_cnt   = 11'd0;
                            n_shift = 32'd0;
                            emit    = 1'b1;
                            if (r_type == i_cfg.put_type_code) begin
                                if (vsh > 32'(MAX_VALUE_BYTES) ||
                                    (12'd7 + {3'd0, r_klen} + {1'b0, vsh[10:0]})
                                        != {1'b0, r_body}) begin
                                    n_halted = 1'b1;
                                    stat     = ST_BAD_LEN;
                                end else begin
                                    n_vlen = vsh[10:0];
                                    if (vsh == 32'd0) begin
                                        kind = KIND_END;
                                        rend = 1'b1;
                                    end else begin
                                        emit    = 1'b0;
                                        n_phase = PH_VALUE;
                                    end
                                end
                            end else begin
                                n_vlen = 11'd0;
                                if ((12'd7 + {3'd0, r_klen}) != {1'b0, r_body}) begin
                                    n_halted = 1'b1;
                                    stat     = ST_BAD_LEN;
                                end else begin
                                    kind = KIND_END;
                                    rend = 1'b1;
                                end
                            end
                        end
                    end
                    PH_VALUE: begin
                        n_crc = crc_next;
                        n_cnt = cnt_inc[10:0];
                        emit  = 1'b1;
                        kind  = KIND_VALUE;
                        dbyte = b;
                        rend  = (cnt_inc >= {1'b0, r_vlen});
                    end
                    default: begin
                        emit     = 1'b1;
                        n_halted = 1'b1;
                        stat     = ST_BAD_LEN;
                    end
                endcase
                // body closed: check the CRC and rearm for the next record
                if (rend) begin
                    n_phase = PH_CRC;
                    n_cnt   = 11'd0;
                    n_shift = 32'd0;
                    if (~crc_next != r_stored) begin
                        n_halted = 1'b1;
                        stat     = ST_CRC;
                    end
                end
            end
        end

        o_res_valid        = emit;
        o_res.item_kind    = kind;
        o_res.data_byte    = dbyte;
        o_res.record_kind  = n_type;
        o_res.record_end   = rend;
        o_res.status       = stat;
        o_res.key_length   = n_klen;
        o_res.value_length = n_vlen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_CRC;
            r_cnt    <= 11'd0;
            r_shift  <= 32'd0;
            r_stored <= 32'd0;
            r_crc    <= '1;
            r_body   <= 11'd0;
            r_type   <= 8'd0;
            r_klen   <= 9'd0;
            r_vlen   <= 11'd0;
            r_halted <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_cnt    <= n_cnt;
            r_shift  <= n_shift;
            r_stored <= n_stored;
            r_crc    <= n_crc;
            r_body   <= n_body;
            r_type   <= n_type;
            r_klen   <= n_klen;
            r_vlen   <= n_vlen;
            r_halted <= n_halted;
        end
    end

    a_halt_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |-> !o_res_valid) else $error("result after halt");

    a_stop_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.item_kind == KIND_STOP) |=> r_halted)
        else $error("stop beat did not halt");

endmodule

// File: hw/rtl/lrd_out_fifo.sv
// ----------------------------------------------------------------------------
// lrd_out_fifo: result queue
// Four-entry queue holding result beats until the consumer pops them.
// ----------------------------------------------------------------------------
module lrd_out_fifo
    import lrd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_wr,
    input  t_result i_wdata,
    output logic    o_full,
    input  logic    i_rd,
    output logic    o_empty,
    output t_result o_rdata
);
    t_result    r_mem [4];
    logic [1:0] r_wptr, r_rptr;
    logic [2:0] r_count;

    assign o_full  = (r_count == 3'd4);
    assign o_empty = (r_count == 3'd0);
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_wr && !o_full) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 2'd0;
            r_rptr  <= 2'd0;
            r_count <= 3'd0;
        end else begin
            if (i_wr && !o_full) r_wptr <= r_wptr + 2'd1;
            if (i_rd && !o_empty) r_rptr <= r_rptr + 2'd1;
            r_count <= r_count + 3'(i_wr && !o_full) - 3'(i_rd && !o_empty);
        end
    end

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_wr && o_full)) else $error("result written into full queue");

    a_out_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'd4) else $error("result queue overfilled");

endmodule

// File: tb/lrd_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lrd_checker: result predictor and scoreboard for the log record deframer
// Watches the config port and both queue sides, predicts each result beat
// and compares it field by field with what the block pops out.
// ----------------------------------------------------------------------------
module lrd_checker
    import lrd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        push,
    input  logic        full,
    input  logic [7:0]  i_log_byte,
    input  logic        i_end_marker,
    input  logic        empty,
    input  logic        pop,
    input  logic [1:0]  i_item_kind,
    input  logic [7:0]  i_data_byte,
    input  logic [7:0]  i_record_kind,
    input  logic        i_record_end,
    input  logic [2:0]  i_status,
    input  logic [8:0]  i_key_length,
    input  logic [10:0] i_value_length,
    output int          o_fail_count,
    output int          o_pending
);

    logic        hdr_be;
    logic [7:0]  put_code;
    t_phase      ph;
    logic [31:0] cnt, shreg, crc_hdr, crc_run, body_len, klen, vlen;
    logic [7:0]  rec_type;
    bit          halted;
    t_result     verdict_q[$];

    function automatic logic [31:0] crc_update(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            r = r[0] ? ({1'b0, r[31:1]} ^ 32'hEDB8_8320) : {1'b0, r[31:1]};
        end
        return r;
    endfunction

    task automatic add_result(input logic [1:0] kind, input logic [7:0] data,
                              input logic rend, input logic [2:0] st);
        t_result r;
        r.item_kind    = kind;
        r.data_byte    = data;
        r.record_kind  = rec_type;
        r.record_end   = rend;
        r.status       = st;
        r.key_length   = klen[8:0];
        r.value_length = vlen[10:0];
        verdict_q.push_back(r);
    endtask

    task automatic halt_with(input logic [2:0] st);
        halted = 1;
        add_result(KIND_STOP, 8'd0, 1'b0, st);
    endtask

    // closes the body: commit if the CRC matches, else flag and halt
    task automatic close_record(input logic [1:0] kind, input logic [7:0] data);
        bit ok;
        ok = ((crc_run ^ 32'hFFFF_FFFF) == crc_hdr);
        ph = PH_CRC;
        cnt = 0;
        shreg = 0;
        if (!ok) halted = 1;
        add_result(kind, data, 1'b1, ok ? ST_OK : ST_CRC);
    endtask

    task automatic take_header(input logic [7:0] b);
        if (hdr_be) shreg = {shreg[23:0], b};
        else shreg = shreg | ({24'd0, b} << (8 * cnt[1:0]));
        cnt++;
    endtask

    task automatic predict_beat(input logic [7:0] b, input logic em);
        if (halted) return;
        if (em) begin
            halt_with((ph == PH_CRC && cnt == 0) ? ST_CLEAN : ST_TRUNC);
            return;
        end
        case (ph)
            PH_CRC: begin
                if (cnt == 0) begin
                    rec_type = 0;
                    klen = 0;
                    vlen = 0;
                end
                take_header(b);
                if (cnt == 4) begin
                    crc_hdr = shreg;
                    ph = PH_LEN;
                    cnt = 0;
                    shreg = 0;
                end
            end
            PH_LEN: begin
                take_header(b);
                if (cnt == 4) begin
                    body_len = shreg;
                    cnt = 0;
                    shreg = 0;
                    if (body_len == 0 || body_len > BODY_LIMIT) halt_with(ST_BAD_LEN);
                    else begin
                        crc_run = 32'hFFFF_FFFF;
                        ph = PH_TYPE;
                    end
                end
            end
            PH_TYPE: begin
                crc_run = crc_update(crc_run, b);
                rec_type = b;
                ph = PH_KLEN;
            end
            PH_KLEN: begin
                crc_run = crc_update(crc_run, b);
                shreg = {16'd0, shreg[7:0], b};
                cnt++;
                if (cnt == 2) begin
                    klen = shreg;
                    cnt = 0;
                    shreg = 0;
                    if (klen > MAX_KEY_BYTES || 7 + klen > body_len) halt_with(ST_BAD_LEN);
                    else ph = (klen != 0) ? PH_KEY : PH_VLEN;
                end
            end
            PH_KEY: begin
                crc_run = crc_update(crc_run, b);
                cnt++;
                if (cnt >= klen) begin
                    ph = PH_VLEN;
                    cnt = 0;
                    shreg = 0;
                end
                add_result(KIND_KEY, b, 1'b0, ST_OK);
            end
            PH_VLEN: begin
                crc_run = crc_update(crc_run, b);
                shreg = {shreg[23:0], b};
                cnt++;
                if (cnt == 4) begin
                    cnt = 0;
                    if (rec_type == put_code) begin
                        // put: value length must fill the body exactly
                        if (shreg > MAX_VALUE_BYTES || 7 + klen + shreg != body_len) begin
                            shreg = 0;
                            halt_with(ST_BAD_LEN);
                        end else begin
                            vlen = shreg;
                            shreg = 0;
                            if (vlen == 0) close_record(KIND_END, 8'd0);
                            else ph = PH_VALUE;
                        end
                    end else begin
                        // any other type: value length ignored, no value bytes
                        shreg = 0;
                        vlen = 0;
                        if (7 + klen != body_len) halt_with(ST_BAD_LEN);
                        else close_record(KIND_END, 8'd0);
                    end
                end
            end
            PH_VALUE: begin
                crc_run = crc_update(crc_run, b);
                cnt++;
                if (cnt >= vlen) close_record(KIND_VALUE, b);
                else add_result(KIND_VALUE, b, 1'b0, ST_OK);
            end
            default: halt_with(ST_BAD_LEN);
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
        if (exp !== act) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp, act);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result exp;
        if (!i_rst_n) begin
            hdr_be = 0;
            put_code = 8'd0;
            ph = PH_CRC;
            cnt = 0;
            shreg = 0;
            crc_hdr = 0;
            crc_run = 32'hFFFF_FFFF;
            body_len = 0;
            rec_type = 0;
            klen = 0;
            vlen = 0;
            halted = 0;
            o_fail_count = 0;
            verdict_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_HDR_BE) hdr_be = i_cfg_wdata[0];
                else if (i_cfg_idx == CFG_PUT_CODE) put_code = i_cfg_wdata;
            end
            if (push && !full) predict_beat(i_log_byte, i_end_marker);
            if (!empty && pop) begin
                if (verdict_q.size() == 0) begin
                    $error("result beat with nothing expected (kind %0d)", i_item_kind);
                    o_fail_count++;
                end else begin
                    exp = verdict_q.pop_front();
                    check_field("item_kind", exp.item_kind, i_item_kind);
                    check_field("data_byte", exp.data_byte, i_data_byte);
                    check_field("record_kind", exp.record_kind, i_record_kind);
                    check_field("record_end", exp.record_end, i_record_end);
                    check_field("status", exp.status, i_status);
                    check_field("key_length", exp.key_length, i_key_length);
                    check_field("value_length", exp.value_length, i_value_length);
                end
            end
        end
        o_pending <= verdict_q.size();
    end

endmodule

// File: tb/tb_log_record_deframer_crc_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_log_record_deframer_crc_check: stimulus and verdict for the deframer
// Streams framed log records (puts, deletes, other types) through the block
// under changing header byte order and type codes, then ends the log with
// one randomly chosen terminal case. The checker module scores the results.
// ----------------------------------------------------------------------------
module tb_log_record_deframer_crc_check;
    import lrd_pkg::*;

    localparam logic [1:0] CFG_DEL_CODE = 2'd2;   // delete code register index
    localparam int SETTLE_CYCLES = 16;             // covers both internal queues

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic [1:0]  i_cfg_idx = '0;
    logic [7:0]  i_cfg_wdata = '0;
    logic        push = 0;
    logic        full;
    logic [7:0]  i_log_byte = '0;
    logic        i_end_marker = 0;
    logic        empty;
    logic        pop = 0;
    logic [1:0]  o_item_kind;
    logic [7:0]  o_data_byte;
    logic [7:0]  o_record_kind;
    logic        o_record_end;
    logic [2:0]  o_status;
    logic [8:0]  o_key_length;
    logic [10:0] o_value_length;
    int          fail_count;
    int          pending;

    // shadow of the config the stimulus frames records for
    logic        hdr_be = 0;
    logic [7:0]  put_code = 8'd0;
    logic [7:0]  del_code = 8'd1;

    int burst_left = 0;
    int bytes_sent = 0;

    always #4 i_clk = ~i_clk;

    log_record_deframer_crc_check uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_wdata(i_cfg_wdata),
        .push(push), .full(full), .i_log_byte(i_log_byte), .i_end_marker(i_end_marker),
        .empty(empty), .pop(pop),
        .o_item_kind(o_item_kind), .o_data_byte(o_data_byte), .o_record_kind(o_record_kind),
        .o_record_end(o_record_end), .o_status(o_status), .o_key_length(o_key_length),
        .o_value_length(o_value_length)
    );

    lrd_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_wdata(i_cfg_wdata),
        .push(push), .full(full), .i_log_byte(i_log_byte), .i_end_marker(i_end_marker),
        .empty(empty), .pop(pop),
        .i_item_kind(o_item_kind), .i_data_byte(o_data_byte), .i_record_kind(o_record_kind),
        .i_record_end(o_record_end), .i_status(o_status), .i_key_length(o_key_length),
        .i_value_length(o_value_length),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Receiver: switches at random between free-running, random, heavy stall
    // and periodic stall pop patterns.
    int pop_mode = 0;
    int pop_left = 0;
    always @(posedge i_clk) begin
        if (pop_left == 0) begin
            pop_mode = $urandom_range(0, 3);
            pop_left = $urandom_range(20, 200);
        end else begin
            pop_left--;
        end
        case (pop_mode)
            0:       pop <= 1'b1;
            1:       pop <= 1'($urandom_range(0, 1));
            2:       pop <= ($urandom_range(0, 3) == 0);
            default: pop <= (pop_left[2:0] != 3'd0);
        endcase
    end

    // CRC-32 over a record body, finished (inverted)
    function automatic logic [31:0] body_crc(input logic [7:0] body[$]);
        logic [31:0] c;
        c = 32'hFFFF_FFFF;
        foreach (body[i]) begin
            c ^= {24'd0, body[i]};
            for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 32'hEDB8_8320) : (c >> 1);
        end
        return ~c;
    endfunction

    // One input beat; the sender runs in bursts with random gaps between them.
    task automatic send_beat(input logic [7:0] b, input logic em);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(1, 12);
        end
        push <= 1'b1;
        i_log_byte <= b;
        i_end_marker <= em;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        burst_left--;
        bytes_sent++;
    endtask

    // Drop push and wait until every expected result beat has been popped.
    task automatic drain();
        push <= 1'b0;
        burst_left = 0;
        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_HDR_BE) hdr_be = val[0];
        else if (idx == CFG_PUT_CODE) put_code = val;
        else del_code = val;
    endtask

    // Frames and sends one record. vlen is the value length field, nval the
    // number of value bytes appended. len_fix/crc_xor corrupt the header;
    // cut >= 0 stops after that many bytes and sends the end marker.
    task automatic send_record(input logic [7:0] typ, input logic [15:0] klen,
                               input logic [31:0] vlen, input int nval,
                               input logic use_len, input logic [31:0] len_fix,
                               input logic [31:0] crc_xor, input int cut);
        logic [7:0]  body[$];
        logic [7:0]  all[$];
        logic [31:0] crc, len;
        body.push_back(typ);
        body.push_back(klen[15:8]);
        body.push_back(klen[7:0]);
        for (int i = 0; i < klen; i++) body.push_back(8'($urandom_range(0, 255)));
        for (int i = 3; i >= 0; i--) body.push_back(vlen[8*i +: 8]);
        for (int i = 0; i < nval; i++) body.push_back(8'($urandom_range(0, 255)));
        crc = body_crc(body) ^ crc_xor;
        len = use_len ? len_fix : body.size();
        for (int i = 0; i < 4; i++) all.push_back(hdr_be ? crc[8*(3-i) +: 8] : crc[8*i +: 8]);
        for (int i = 0; i < 4; i++) all.push_back(hdr_be ? len[8*(3-i) +: 8] : len[8*i +: 8]);
        all = {all, body};
        foreach (all[i]) begin
            if (cut >= 0 && i >= cut) break;
            send_beat(all[i], 1'b0);
        end
        if (cut >= 0) send_beat(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // Well-formed record: put carries its value, others a junk value length.
    task automatic good_record(input logic [7:0] typ, input logic [15:0] klen,
                               input logic [31:0] vlen);
        if (typ == put_code) send_record(typ, klen, vlen, vlen, 0, 0, 0, -1);
        else send_record(typ, klen, $urandom, 0, 0, 0, 0, -1);
    endtask

    task automatic random_record();
        logic [7:0]  typ;
        logic [15:0] klen;
        logic [31:0] vlen;
        int sel;
        sel = $urandom_range(0, 99);
        typ = (sel < 45) ? put_code : (sel < 80) ? del_code : 8'($urandom_range(0, 255));
        klen = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 10));
        if ($urandom_range(0, 49) == 0) klen = 16'($urandom_range(250, 256));
        vlen = ($urandom_range(0, 6) == 0) ? 0 : $urandom_range(1, 16);
        good_record(typ, klen, vlen);
    endtask

    task automatic random_config();
        case ($urandom_range(0, 3))
            0: write_reg(CFG_HDR_BE, 8'($urandom_range(0, 1)));
            1: write_reg(CFG_PUT_CODE,
                         $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : 8'hFF);
            2: write_reg(CFG_DEL_CODE, 8'($urandom_range(0, 255)));
            default: write_reg(CFG_DEL_CODE, put_code);   // put and delete alike
        endcase
    endtask

    // Ends the log with one terminal case; the block halts afterwards.
    task automatic terminal_case();
        case ($urandom_range(0, 6))
            0: send_beat(8'($urandom_range(0, 255)), 1'b1);                   // clean end
            1: send_record(put_code, 4, 6, 6, 0, 0, 0, $urandom_range(1, 20)); // truncated
            2: send_record(put_code, 3, 5, 5, 0, 0, 32'h0000_0100, -1);       // CRC mismatch
            3: send_record(del_code, 2, 0, 0, 1,                              // bad length
                           $urandom_range(0, 1) ? 32'd0 : BODY_LIMIT + 1 + $urandom_range(0, 9),
                           0, -1);
            4: send_record(put_code, $urandom_range(0, 1) ? 16'd257 : 16'hFFFF, // key too long
                           0, 0, 1, 32'd300, 0, 11);
            5: send_record(put_code, 2, 32'(MAX_VALUE_BYTES + 1), 0, 1,       // value too long
                           32'(7 + 2 + MAX_VALUE_BYTES + 1), 0, -1);
            default: send_record(put_code, 2, 4, 4, 1, 32'd20, 0, -1);       // value/length clash
        endcase
        // the halted block swallows these
        repeat (8) send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset codes, empty key and value, non-put type
        good_record(put_code, 0, 0);
        good_record(del_code, 1, 0);
        good_record(8'h7E, 0, 0);
        good_record(put_code, 1, 2);
        drain();
        write_reg(CFG_HDR_BE, 8'd1);
        write_reg(CFG_PUT_CODE, 8'hFF);
        write_reg(CFG_DEL_CODE, 8'hFF);
        good_record(8'hFF, 2, 1);                 // put and delete codes equal
        drain();
        write_reg(CFG_DEL_CODE, 8'h00);
        write_reg(CFG_HDR_BE, 8'd0);
        good_record(8'h00, 1, 0);
        good_record(8'hFF, 0, 1);

        // random records; one maximum key on the way
        for (int n = 0; bytes_sent < 850; n++) begin
            if ($urandom_range(0, 5) == 0) begin
                drain();
                random_config();
            end
            if (n == 10) good_record(put_code, 16'(MAX_KEY_BYTES), 3);
            else random_record();
        end

        terminal_case();
        drain();
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
